/* rtl/sccfbm_pkg.sv */
// ----------------------------------------------------------------------------
// sccfbm_pkg: shared constants and types for the flash bank mapper
// Address map boundaries, register codes and read source codes.
// ----------------------------------------------------------------------------
package sccfbm_pkg;

  localparam int BANK_INDEX_BITS_DEFAULT = 11;

  localparam int BANK_W   = 14;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int FLASH_W  = 24;
  localparam int PAGE_W   = 13;
  localparam int BANKS    = 4;

  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [1:0]        page_t;
  typedef logic [1:0]        src_t;

  localparam src_t SRC_NONE  = 2'd0;
  localparam src_t SRC_FLASH = 2'd1;
  localparam src_t SRC_SCC   = 2'd2;

  localparam logic [ADDR_W-1:0] WIN_LO      = 16'h2000;
  localparam logic [ADDR_W-1:0] WIN_HI      = 16'hC000;
  localparam logic [ADDR_W-1:0] CTRL_HI     = 16'h4000;
  localparam logic [ADDR_W-1:0] CTRL_REG_LO = 16'h3800;
  localparam logic [ADDR_W-1:0] SCC_LO      = 16'h9800;
  localparam logic [ADDR_W-1:0] SCC_HI      = 16'hA000;
  localparam logic [ADDR_W-1:0] DAC_HI      = 16'h5000;
  localparam logic [ADDR_W-1:0] BANK_SEL_MASK  = 16'h1800;
  localparam logic [ADDR_W-1:0] BANK_SEL_MATCH = 16'h1000;

  localparam logic [5:0]        SCC_ENABLE  = 6'h3F;
  localparam logic [DATA_W-1:0] REG_DAC_CTL = 8'hFB;
  localparam logic [DATA_W-1:0] REG_DAC_OUT = 8'hFC;
  localparam int                DAC_EN_BIT  = 4;
  localparam int                MODE16_BIT  = 1;

endpackage

/* rtl/scc_flash_bank_mapper.sv */
// ----------------------------------------------------------------------------
// scc_flash_bank_mapper: bank mapper for an 8 KB-paged cartridge
// Decodes one CPU bus request into a flash, sound-chip or DAC target and
// keeps the bank, offset, mode and DAC control registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one bus request: mode (0 read,
//   1 write), bus_address and write_data. Output channel (out_valid/
//   out_ready) returns one result per request: read source, flash, sound
//   and DAC strobes, flash_address, scc_register and data_out.
//   A request is registered on acceptance, decoded against the current
//   mapping and moved into the result register once that register is free,
//   where the register updates of a write also take effect. Throughput is
//   one request per cycle while out_ready stays high, bounded by the single
//   decode stage between the request and result registers.
//   A write to a bank register still maps its own flash write through the
//   old bank value.
//   Reset loads banks 0..3 with 0, 1, 2, 3 and clears offset, mode and DAC
//   control, and empties both stages. When the receiver stalls, the result
//   holds, the request stage fills, and in_ready drops until out_ready.
// ----------------------------------------------------------------------------
module scc_flash_bank_mapper
  import sccfbm_pkg::*;
#(
  parameter int BANK_INDEX_BITS = BANK_INDEX_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [ADDR_W-1:0] bus_address,
  input  logic [DATA_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        read_source,
  output logic              flash_read_strobe,
  output logic              flash_write_strobe,
  output logic [FLASH_W-1:0] flash_address,
  output logic              scc_read_strobe,
  output logic              scc_write_strobe,
  output logic [DATA_W-1:0] scc_register,
  output logic              dac_write_strobe,
  output logic [DATA_W-1:0] data_out
);

  localparam bank_t BANK_MASK = bank_t'((1 << BANK_INDEX_BITS) - 1);

  logic              req_valid;
  logic              req_mode;
  logic [ADDR_W-1:0] req_address;
  logic [DATA_W-1:0] req_data;
  logic              advance;

  bank_t             bank [BANKS];
  bank_t             bank_offset;
  logic [1:0]        operating_mode;
  logic [DATA_W-1:0] dac_control;

  bank_t             bank_next;
  logic              bank_we;
  bank_t             offset_next;
  logic [1:0]        opmode_next;
  logic [DATA_W-1:0] dac_next;

  page_t             page;
  logic [BANK_W:0]   bank_sum;
  bank_t             bank_idx;
  logic [BANK_W+PAGE_W-1:0] flash_full;
  logic              in_win;
  logic              scc_hit;

  src_t              src_c;
  logic              frd_c, fwr_c, srd_c, swr_c, dwr_c;
  logic [FLASH_W-1:0] fad_c;
  logic [DATA_W-1:0] sreg_c, dout_c;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      req_mode    <= mode;
      req_address <= bus_address;
      req_data    <= write_data;
    end
  end

  assign page       = {~req_address[14], req_address[13]};
  assign bank_sum   = {1'b0, bank[page]} + {1'b0, bank_offset};
  assign bank_idx   = bank_sum[BANK_W-1:0] & BANK_MASK;
  assign flash_full = {bank_idx, req_address[PAGE_W-1:0]};
  assign in_win     = (req_address >= WIN_LO) && (req_address < WIN_HI);
  assign scc_hit    = (bank[2][5:0] == SCC_ENABLE) && (req_address >= SCC_LO) &&
                      (req_address < SCC_HI);

  always_comb begin
    src_c       = SRC_NONE;
    frd_c       = 1'b0;
    fwr_c       = 1'b0;
    srd_c       = 1'b0;
    swr_c       = 1'b0;
    dwr_c       = 1'b0;
    fad_c       = '0;
    sreg_c      = '0;
    dout_c      = '0;
    bank_we     = 1'b0;
    bank_next   = bank[page];
    offset_next = bank_offset;
    opmode_next = operating_mode;
    dac_next    = dac_control;
    if (in_win) begin
      if (!req_mode) begin
        if (req_address >= CTRL_HI) begin
          if (scc_hit) begin
            src_c  = SRC_SCC;
            srd_c  = 1'b1;
            sreg_c = req_address[DATA_W-1:0];
          end else begin
            src_c = SRC_FLASH;
            frd_c = 1'b1;
            fad_c = flash_full[FLASH_W-1:0];
          end
        end
      end else if (req_address < CTRL_HI) begin
        if (req_address >= CTRL_REG_LO) begin
          if (req_address[2]) begin
            opmode_next = req_data[1:0];
          end else if (req_address[0]) begin
            offset_next = {req_data[5:0], bank_offset[7:0]};
          end else begin
            offset_next = {bank_offset[13:8], req_data};
          end
        end
      end else begin
        if (scc_hit) begin
          case (req_address[DATA_W-1:0])
            REG_DAC_CTL: dac_next = req_data;
            REG_DAC_OUT: dwr_c = 1'b1;
            default: begin
              swr_c  = 1'b1;
              sreg_c = req_address[DATA_W-1:0];
            end
          endcase
        end
        if (dac_control[DAC_EN_BIT] && (req_address < DAC_HI)) begin
          dwr_c = 1'b1;
        end else begin
          fwr_c = 1'b1;
          fad_c = flash_full[FLASH_W-1:0];
        end
        if ((req_address & BANK_SEL_MASK) == BANK_SEL_MATCH) begin
          bank_we = 1'b1;
          if (operating_mode[MODE16_BIT]) begin
            if (req_address[0]) begin
              bank_next = {req_data[5:0], bank[page][7:0]};
            end else begin
              bank_next = {bank[page][13:8], req_data};
            end
          end else begin
            bank_next = {6'd0, req_data};
          end
        end
        dout_c = req_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANKS; i++) begin
        bank[i] <= bank_t'(i);
      end
      bank_offset    <= '0;
      operating_mode <= '0;
      dac_control    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        if (bank_we) begin
          bank[page] <= bank_next;
        end
        bank_offset    <= offset_next;
        operating_mode <= opmode_next;
        dac_control    <= dac_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_source        <= src_c;
      flash_read_strobe  <= frd_c;
      flash_write_strobe <= fwr_c;
      flash_address      <= fad_c;
      scc_read_strobe    <= srd_c;
      scc_write_strobe   <= swr_c;
      scc_register       <= sreg_c;
      dac_write_strobe   <= dwr_c;
      data_out           <= dout_c;
    end
  end

  a_write_no_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && (flash_write_strobe || scc_write_strobe || dac_write_strobe)
      |-> read_source == SRC_NONE)
    else $error("write result carries a read source");

  a_flash_read_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && flash_read_strobe |-> read_source == SRC_FLASH && !scc_read_strobe)
    else $error("flash read without flash read source");

  a_scc_read_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && scc_read_strobe |-> read_source == SRC_SCC && flash_address == '0)
    else $error("sound read with wrong source or stray flash address");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    req_valid && !advance |=> req_valid && $stable(req_address))
    else $error("request stage lost a pending request");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !req_valid)
    else $error("pipeline not empty after reset");

endmodule

/* sim/scc_route_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scc_route_checker: route predictor and result checker for the bank mapper
// Watches both channels of the mapper. Each accepted bus request is decoded
// against a private copy of the bank, offset, mode and DAC control state.
// The expected route is queued and compared field by field with the next
// accepted result. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module scc_route_checker
  import sccfbm_pkg::*;
#(
  parameter int BANK_INDEX_BITS = BANK_INDEX_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic [ADDR_W-1:0]  bus_address,
  input  logic [DATA_W-1:0]  write_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         read_source,
  input  logic               flash_read_strobe,
  input  logic               flash_write_strobe,
  input  logic [FLASH_W-1:0] flash_address,
  input  logic               scc_read_strobe,
  input  logic               scc_write_strobe,
  input  logic [DATA_W-1:0]  scc_register,
  input  logic               dac_write_strobe,
  input  logic [DATA_W-1:0]  data_out,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    src_t               source;
    logic               flash_rd;
    logic               flash_wr;
    logic [FLASH_W-1:0] flash_addr;
    logic               scc_rd;
    logic               scc_wr;
    logic [DATA_W-1:0]  scc_sel;
    logic               dac_wr;
    logic [DATA_W-1:0]  dout;
  } bus_route_t;

  bank_t             bank_reg [BANKS];
  bank_t             bank_ofs;
  logic [1:0]        op_mode;
  logic [DATA_W-1:0] dac_ctl;

  bus_route_t expected_routes [$];
  bus_route_t want;
  bus_route_t got;

  function automatic logic [FLASH_W-1:0] flash_addr_of(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] rel;
    logic [31:0]       bank;
    rel  = a - CTRL_HI;
    bank = (32'(bank_reg[rel[14:13]]) + 32'(bank_ofs)) & ((32'd1 << BANK_INDEX_BITS) - 32'd1);
    return FLASH_W'((bank << PAGE_W) + 32'(a[PAGE_W-1:0]));
  endfunction

  function automatic logic sound_hit(logic [ADDR_W-1:0] a);
    return bank_reg[2][5:0] == SCC_ENABLE && a >= SCC_LO && a < SCC_HI;
  endfunction

  task automatic predict_route(input logic m, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d, output bus_route_t r);
    logic [ADDR_W-1:0] rel;
    logic [1:0]        pg;
    r   = '0;
    rel = a - CTRL_HI;
    pg  = rel[14:13];
    if (a >= WIN_LO && a < WIN_HI) begin
      if (!m) begin
        if (a >= CTRL_HI) begin
          if (sound_hit(a)) begin
            r.source = SRC_SCC;
            r.scc_rd = 1'b1;
            r.scc_sel = a[7:0];
          end else begin
            r.source = SRC_FLASH;
            r.flash_rd = 1'b1;
            r.flash_addr = flash_addr_of(a);
          end
        end
      end else if (a < CTRL_HI) begin
        if (a >= CTRL_REG_LO) begin
          if (a[2]) op_mode = d[1:0];
          else if (a[0]) bank_ofs = {d[5:0], bank_ofs[7:0]};
          else bank_ofs = {bank_ofs[13:8], d};
        end
      end else begin
        if (sound_hit(a)) begin
          if (a[7:0] == REG_DAC_CTL) begin
            dac_ctl = d;
          end else if (a[7:0] == REG_DAC_OUT) begin
            r.dac_wr = 1'b1;
          end else begin
            r.scc_wr = 1'b1;
            r.scc_sel = a[7:0];
          end
        end
        if (dac_ctl[DAC_EN_BIT] && a < DAC_HI) begin
          r.dac_wr = 1'b1;
        end else begin
          r.flash_wr = 1'b1;
          r.flash_addr = flash_addr_of(a);
        end
        // bank update lands after the flash write above used the old mapping
        if ((a & BANK_SEL_MASK) == BANK_SEL_MATCH) begin
          if (!op_mode[MODE16_BIT]) bank_reg[pg] = {6'd0, d};
          else if (a[0]) bank_reg[pg] = {d[5:0], bank_reg[pg][7:0]};
          else bank_reg[pg] = {bank_reg[pg][13:8], d};
        end
        if (r.flash_wr || r.scc_wr || r.dac_wr) r.dout = d;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BANKS; k++) bank_reg[k] = bank_t'(k);
      bank_ofs = '0;
      op_mode  = '0;
      dac_ctl  = '0;
      expected_routes.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_route(mode, bus_address, write_data, want);
        expected_routes.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{read_source, flash_read_strobe, flash_write_strobe, flash_address,
                scc_read_strobe, scc_write_strobe, scc_register, dac_write_strobe,
                data_out};
        if (expected_routes.size() == 0) begin
          $error("unexpected result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_routes.pop_front();
          check_field("read_source", 32'(want.source), 32'(got.source));
          check_field("flash_read_strobe", 32'(want.flash_rd), 32'(got.flash_rd));
          check_field("flash_write_strobe", 32'(want.flash_wr), 32'(got.flash_wr));
          check_field("flash_address", 32'(want.flash_addr), 32'(got.flash_addr));
          check_field("scc_read_strobe", 32'(want.scc_rd), 32'(got.scc_rd));
          check_field("scc_write_strobe", 32'(want.scc_wr), 32'(got.scc_wr));
          check_field("scc_register", 32'(want.scc_sel), 32'(got.scc_sel));
          check_field("dac_write_strobe", 32'(want.dac_wr), 32'(got.dac_wr));
          check_field("data_out", 32'(want.dout), 32'(got.dout));
        end
      end
    end
    pending = expected_routes.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the flash bank mapper
// Drives directed and random bus requests with random gaps and receiver
// stalls, including a long receiver hold-off and a drain pause. Results are
// checked by the route checker instantiated beside the mapper.
// ----------------------------------------------------------------------------
module tb_top;
  import sccfbm_pkg::*;

  localparam int BANK_BITS   = BANK_INDEX_BITS_DEFAULT;
  localparam int NUM_RANDOM  = 1000;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [ADDR_W-1:0]  bus_address;
  logic [DATA_W-1:0]  write_data;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         read_source;
  logic               flash_read_strobe;
  logic               flash_write_strobe;
  logic [FLASH_W-1:0] flash_address;
  logic               scc_read_strobe;
  logic               scc_write_strobe;
  logic [DATA_W-1:0]  scc_register;
  logic               dac_write_strobe;
  logic [DATA_W-1:0]  data_out;

  int fail_count;
  int pending;
  int cycle_count;
  int hold_left;
  bit steady;
  bit hold_req;
  bit hold_done;

  scc_flash_bank_mapper #(.BANK_INDEX_BITS(BANK_BITS)) uut (.*);

  scc_route_checker #(.BANK_INDEX_BITS(BANK_BITS)) route_chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[scc_flash_bank_mapper] ERROR");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  task automatic send_request(input logic m, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
    in_valid    <= 1'b1;
    mode        <= m;
    bus_address <= a;
    write_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_request(output logic m, output logic [ADDR_W-1:0] a,
                              output logic [DATA_W-1:0] d);
    int unsigned sel;
    int unsigned pg;
    sel = $urandom_range(99);
    pg  = $urandom_range(3);
    m   = 1'($urandom_range(1));
    d   = 8'($urandom_range(255));
    if (sel < 15) begin
      m = 1'b1;
      a = ADDR_W'(32'h3800 + $urandom_range(32'h07FF));
    end else if (sel < 35) begin
      m = 1'b1;
      a = ADDR_W'(32'h5000 + pg * 32'h2000 + $urandom_range(32'h07FF));
      if (pg == 2 && $urandom_range(1)) d = d | 8'h3F;
    end else if (sel < 55) begin
      a = ADDR_W'(32'h9800 + $urandom_range(32'h07FF));
      if ($urandom_range(2) == 0) a[7:0] = $urandom_range(1) ? REG_DAC_CTL : REG_DAC_OUT;
    end else if (sel < 65) begin
      a = ADDR_W'(32'h4000 + $urandom_range(32'h0FFF));
    end else if (sel < 97) begin
      a = ADDR_W'($urandom_range(32'h2000, 32'hBFFF));
    end else begin
      a = $urandom_range(1) ? ADDR_W'($urandom_range(32'h1FFF))
                            : ADDR_W'($urandom_range(32'hC000, 32'hFFFF));
    end
  endtask

  initial begin
    logic              m;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = 1'b0;
    bus_address = '0;
    write_data  = '0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(1'b0, 16'h2000, 8'h00);
    send_request(1'b0, 16'hBFFF, 8'h00);
    send_request(1'b0, 16'h4000, 8'hFF);
    send_request(1'b1, 16'h2000, 8'h55);
    send_request(1'b1, 16'h3800, 8'h05);
    send_request(1'b1, 16'h3801, 8'hFF);
    send_request(1'b0, 16'h6000, 8'h00);
    send_request(1'b1, 16'h3800, 8'h00);
    send_request(1'b1, 16'h3801, 8'h00);
    send_request(1'b1, 16'h9000, 8'h3F);
    send_request(1'b0, 16'h9800, 8'h00);
    send_request(1'b1, 16'h9810, 8'hAA);
    send_request(1'b1, 16'h98FB, 8'h10);
    send_request(1'b1, 16'h4000, 8'h77);
    send_request(1'b1, 16'h98FC, 8'h33);
    send_request(1'b1, 16'h98FB, 8'h00);
    send_request(1'b1, 16'h3804, 8'h02);
    send_request(1'b1, 16'h5000, 8'hFF);
    send_request(1'b1, 16'h5001, 8'hFF);
    send_request(1'b0, 16'h4123, 8'h00);
    send_request(1'b1, 16'h3804, 8'h00);
    send_request(1'b1, 16'h5000, 8'h00);
    send_request(1'b0, 16'h0000, 8'h00);
    send_request(1'b1, 16'hFFFF, 8'hFF);
    send_request(1'b0, 16'hC000, 8'h00);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) steady = 1'b1;
      if (n == 500) steady = 1'b0;
      if (n == 600) hold_req = 1'b1;
      if (n == 800) begin
        // drain
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end else if (!steady && $urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      pick_request(m, a, d);
      send_request(m, a, d);
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("[scc_flash_bank_mapper] OK");
    end else begin
      $display("[scc_flash_bank_mapper] ERROR");
    end
    $finish;
  end

endmodule
